// File: sv/sfe_pkg.sv
// Shared types and constants for the SPS frame size extractor.
// Microprogram counter codes, control word layout, status codes.
// No dependencies.
package sfe_pkg;

  localparam int unsigned MaxPrefixZeros = 32;
  localparam int unsigned LzW = $clog2(MaxPrefixZeros + 1);
  localparam int unsigned AccW = 33;
  localparam int unsigned PhW = 5;
  localparam int unsigned IdxW = 3;

  localparam logic [7:0] ProfileBase = 8'd66;
  localparam logic [7:0] ProfileHigh = 8'd100;
  localparam logic [IdxW-1:0] ProfileIdx = 3'd1;
  localparam logic [IdxW-1:0] BaseStartIdx = 3'd4;
  localparam logic [IdxW-1:0] HighStartIdx = 3'd5;
  localparam logic [IdxW-1:0] IdxMax = 3'd7;

  typedef logic [PhW-1:0] phase_t;

  localparam phase_t PH_HEADER      = 5'd0;
  localparam phase_t PH_WAIT_BASE   = 5'd1;
  localparam phase_t PH_WAIT_HIGH   = 5'd2;
  localparam phase_t PH_SET_ID      = 5'd3;
  localparam phase_t PH_FRAME_NUM   = 5'd4;
  localparam phase_t PH_ORDER_TYPE  = 5'd5;
  localparam phase_t PH_POC_LSB     = 5'd6;
  localparam phase_t PH_NUM_REF0    = 5'd7;
  localparam phase_t PH_ZERO_FLAG   = 5'd8;
  localparam phase_t PH_OFF_NONREF  = 5'd9;
  localparam phase_t PH_OFF_TB      = 5'd10;
  localparam phase_t PH_CYCLE_COUNT = 5'd11;
  localparam phase_t PH_CYCLE_ENTRY = 5'd12;
  localparam phase_t PH_NUM_REF1    = 5'd13;
  localparam phase_t PH_GAP_FLAG    = 5'd14;
  localparam phase_t PH_WIDTH       = 5'd15;
  localparam phase_t PH_HEIGHT      = 5'd16;
  localparam phase_t PH_DONE        = 5'd17;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PROFILE = 2'd1;
  localparam logic [1:0] STAT_ORDER   = 2'd2;
  localparam logic [1:0] STAT_TRUNC   = 2'd3;

  typedef enum logic {
    K_CODE = 1'b0,
    K_FLAG = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NEXT   = 3'd0,
    ACT_ORDER  = 3'd1,
    ACT_CNT    = 3'd2,
    ACT_ENTRY  = 3'd3,
    ACT_WIDTH  = 3'd4,
    ACT_HEIGHT = 3'd5
  } act_e;

  typedef struct packed {
    kind_e  kind;
    act_e   act;
    phase_t nxt;
    phase_t alt;
  } ucw_t;

  typedef struct packed {
    logic       hdr;
    logic [7:0] hdr_byte;
    logic       bit_en;
    logic       bit_val;
    logic       finish;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic pend;
    logic sent;
  } stat_t;

endpackage

// File: sv/sfe_ucode_rom.sv
// Control store: one control word per parse step.
// Depends on sfe_pkg.
module sfe_ucode_rom
  import sfe_pkg::*;
(
  input  phase_t phase_i,
  output ucw_t   cw_o
);

  always_comb begin
    unique case (phase_i)
      PH_SET_ID:      cw_o = '{K_CODE, ACT_NEXT,   PH_FRAME_NUM,   PH_DONE};
      PH_FRAME_NUM:   cw_o = '{K_CODE, ACT_NEXT,   PH_ORDER_TYPE,  PH_DONE};
      PH_ORDER_TYPE:  cw_o = '{K_CODE, ACT_ORDER,  PH_POC_LSB,     PH_ZERO_FLAG};
      PH_POC_LSB:     cw_o = '{K_CODE, ACT_NEXT,   PH_NUM_REF0,    PH_DONE};
      PH_NUM_REF0:    cw_o = '{K_CODE, ACT_NEXT,   PH_GAP_FLAG,    PH_DONE};
      PH_ZERO_FLAG:   cw_o = '{K_FLAG, ACT_NEXT,   PH_OFF_NONREF,  PH_DONE};
      PH_OFF_NONREF:  cw_o = '{K_CODE, ACT_NEXT,   PH_OFF_TB,      PH_DONE};
      PH_OFF_TB:      cw_o = '{K_CODE, ACT_NEXT,   PH_CYCLE_COUNT, PH_DONE};
      PH_CYCLE_COUNT: cw_o = '{K_CODE, ACT_CNT,    PH_CYCLE_ENTRY, PH_NUM_REF1};
      PH_CYCLE_ENTRY: cw_o = '{K_CODE, ACT_ENTRY,  PH_CYCLE_ENTRY, PH_NUM_REF1};
      PH_NUM_REF1:    cw_o = '{K_CODE, ACT_NEXT,   PH_GAP_FLAG,    PH_DONE};
      PH_GAP_FLAG:    cw_o = '{K_FLAG, ACT_NEXT,   PH_WIDTH,       PH_DONE};
      PH_WIDTH:       cw_o = '{K_CODE, ACT_WIDTH,  PH_HEIGHT,      PH_DONE};
      PH_HEIGHT:      cw_o = '{K_CODE, ACT_HEIGHT, PH_DONE,        PH_DONE};
      default:        cw_o = '{K_CODE, ACT_NEXT,   PH_DONE,        PH_DONE};
    endcase
  end

endmodule

// File: sv/sfe_bit_engine.sv
// Parse datapath: step counter, Exp-Golomb prefix/suffix unit, held values.
// Executes the control word from sfe_ucode_rom; depends on sfe_pkg.
module sfe_bit_engine
  import sfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [15:0] pend_w_o,
  output logic [15:0] pend_h_o,
  output logic [1:0]  pend_s_o
);

  localparam logic [LzW-1:0] MaxLz = LzW'(MaxPrefixZeros);

  phase_t              phase_q, phase_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [LzW-1:0]      lz_q, lz_d;
  logic [LzW-1:0]      sbl_q, sbl_d;
  logic                sfx_q, sfx_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [31:0]         cyc_q, cyc_d;
  logic [15:0]         wid_q, wid_d;
  logic                sent_q, sent_d;
  logic                pend_q, pend_d;
  logic [15:0]         pw_q, pw_d;
  logic [15:0]         ph_q, ph_d;
  logic [1:0]          ps_q, ps_d;

  ucw_t                cw;
  logic [AccW-1:0]     acc_sh;
  logic [AccW-1:0]     vp1;
  logic [31:0]         v;
  logic [15:0]         scl;
  logic                code_hit;
  logic                emit;
  logic [15:0]         ew, eh;
  logic [1:0]          es;

  sfe_ucode_rom u_rom (
    .phase_i (phase_q),
    .cw_o    (cw)
  );

  assign acc_sh = {acc_q[AccW-2:0], cmd_i.bit_val};
  assign v      = (vp1[AccW-1:32] != '0) ? '1 : (vp1[31:0] - 32'd1);
  assign scl    = (vp1[AccW-1:12] != '0) ? 16'hFFFF : {vp1[11:0], 4'b0000};

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    lz_d     = lz_q;
    sbl_d    = sbl_q;
    sfx_d    = sfx_q;
    acc_d    = acc_q;
    cyc_d    = cyc_q;
    wid_d    = wid_q;
    sent_d   = sent_q;
    pend_d   = pend_q;
    pw_d     = pw_q;
    ph_d     = ph_q;
    ps_d     = ps_q;
    code_hit = 1'b0;
    vp1      = AccW'(1);
    emit     = 1'b0;
    ew       = '0;
    eh       = '0;
    es       = STAT_OK;

    if (cmd_i.hdr) begin
      if (phase_q == PH_HEADER) begin
        if (idx_q == ProfileIdx) begin
          if (cmd_i.hdr_byte == ProfileBase) begin
            phase_d = PH_WAIT_BASE;
          end else if (cmd_i.hdr_byte == ProfileHigh) begin
            phase_d = PH_WAIT_HIGH;
          end else begin
            emit = 1'b1;
            es   = STAT_PROFILE;
          end
        end
      end else if (phase_q == PH_WAIT_BASE && idx_q == BaseStartIdx) begin
        phase_d = PH_SET_ID;
      end else if (phase_q == PH_WAIT_HIGH && idx_q == HighStartIdx) begin
        phase_d = PH_FRAME_NUM;
      end
    end

    if (cmd_i.bit_en) begin
      if (cw.kind == K_FLAG) begin
        phase_d = cw.nxt;
      end else if (!sfx_q) begin
        if (!cmd_i.bit_val && lz_q < MaxLz) begin
          lz_d = lz_q + LzW'(1);
        end else if (lz_q == '0) begin
          code_hit = 1'b1;
        end else begin
          sfx_d = 1'b1;
          sbl_d = lz_q;
          acc_d = AccW'(1);
        end
      end else begin
        acc_d = acc_sh;
        sbl_d = sbl_q - LzW'(1);
        if (sbl_q == LzW'(1)) begin
          sfx_d    = 1'b0;
          lz_d     = '0;
          code_hit = 1'b1;
          vp1      = acc_sh;
        end
      end
    end

    if (code_hit) begin
      unique case (cw.act)
        ACT_NEXT: phase_d = cw.nxt;
        ACT_ORDER: begin
          if (v == 32'd0) begin
            phase_d = cw.nxt;
          end else if (v == 32'd1) begin
            phase_d = cw.alt;
          end else begin
            emit = 1'b1;
            es   = STAT_ORDER;
          end
        end
        ACT_CNT: begin
          cyc_d   = v;
          phase_d = (v == 32'd0) ? cw.alt : cw.nxt;
        end
        ACT_ENTRY: begin
          cyc_d   = cyc_q - 32'd1;
          phase_d = (cyc_q == 32'd1) ? cw.alt : cw.nxt;
        end
        ACT_WIDTH: begin
          wid_d   = scl;
          phase_d = cw.nxt;
        end
        ACT_HEIGHT: begin
          emit = 1'b1;
          ew   = wid_q;
          eh   = scl;
          es   = STAT_OK;
        end
        default: phase_d = PH_DONE;
      endcase
    end

    if (emit) begin
      pend_d  = 1'b1;
      pw_d    = ew;
      ph_d    = eh;
      ps_d    = es;
      sent_d  = 1'b1;
      phase_d = PH_DONE;
    end

    if (cmd_i.finish) begin
      pend_d = 1'b0;
      if (idx_q != IdxMax) begin
        idx_d = idx_q + IdxW'(1);
      end
      if (cmd_i.last) begin
        phase_d = PH_HEADER;
        idx_d   = '0;
        lz_d    = '0;
        sbl_d   = '0;
        sfx_d   = 1'b0;
        acc_d   = '0;
        cyc_d   = '0;
        wid_d   = '0;
        sent_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= '0;
      lz_q    <= '0;
      sbl_q   <= '0;
      sfx_q   <= 1'b0;
      acc_q   <= '0;
      cyc_q   <= '0;
      wid_q   <= '0;
      sent_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      lz_q    <= lz_d;
      sbl_q   <= sbl_d;
      sfx_q   <= sfx_d;
      acc_q   <= acc_d;
      cyc_q   <= cyc_d;
      wid_q   <= wid_d;
      sent_q  <= sent_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q <= pw_d;
    ph_q <= ph_d;
    ps_q <= ps_d;
  end

  assign stat_o.active = (phase_q >= PH_SET_ID) && (phase_q < PH_DONE);
  assign stat_o.pend   = pend_q;
  assign stat_o.sent   = sent_q;
  assign pend_w_o      = pw_q;
  assign pend_h_o      = ph_q;
  assign pend_s_o      = ps_q;

endmodule

// File: sv/h264_sps_frame_size_extractor_top.sv
// Channel  | dir | handshake           | beat fields
// in       | in  | in_valid_i/in_stall_o   | data_byte_i, last_byte_i
// out      | out | out_valid_o/out_stall_i | frame_width_o, frame_height_o, parse_status_o
//
// A byte in the parse window is accepted, runs up to 8 bit steps through the
// Exp-Golomb engine (one code bit per cycle), then finishes. A result that ends the parse
// mid-byte cuts the bit steps short; the sequencer notices it before it finishes.
// Bytes outside the parse window take no bit steps.
// Finish waits while a result is due and the output register is held by stall.
// Reset clears the parser to the header step; last_byte re-arms it.
// Top level: byte sequencer and output register; uses sfe_bit_engine, sfe_pkg.
module h264_sps_frame_size_extractor_top
  import sfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] frame_width_o,
  output logic [15:0] frame_height_o,
  output logic [1:0]  parse_status_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BITS = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  data_q;
  logic        last_q;
  logic        out_valid_q, out_valid_d;
  logic [15:0] ow_q, oh_q;
  logic [1:0]  os_q;
  logic        load;
  logic        need;
  cmd_t        cmd;
  stat_t       st;
  logic [15:0] pend_w, pend_h;
  logic [1:0]  pend_s;

  sfe_bit_engine u_eng (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (st),
    .pend_w_o (pend_w),
    .pend_h_o (pend_h),
    .pend_s_o (pend_s)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign need       = st.pend || (last_q && !st.sent);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.hdr      = 1'b1;
          cmd.hdr_byte = data_byte_i;
          cnt_d        = 3'd7;
          state_d      = ST_BITS;
        end
      end
      ST_BITS: begin
        if (!st.active) begin
          state_d = ST_FIN;
        end else begin
          cmd.bit_en  = 1'b1;
          cmd.bit_val = data_q[cnt_q];
          if (cnt_q == 3'd0) begin
            state_d = ST_FIN;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
      end
      ST_FIN: begin
        if (!(need && out_valid_q && out_stall_i)) begin
          cmd.finish = 1'b1;
          cmd.last   = last_q;
          load       = need;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (load) begin
      ow_q <= st.pend ? pend_w : 16'd0;
      oh_q <= st.pend ? pend_h : 16'd0;
      os_q <= st.pend ? pend_s : STAT_TRUNC;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_width_o  = ow_q;
  assign frame_height_o = oh_q;
  assign parse_status_o = os_q;

endmodule

// File: dv/h264_sps_frame_size_extractor_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for h264_sps_frame_size_extractor_top: SPS byte streams in,
// frame size reports out, compared against an in-bench bit-serial parser model.
// Depends on sfe_pkg and the top module only.
module h264_sps_frame_size_extractor_top_tb;
  import sfe_pkg::*;

  typedef struct {
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  status;
  } size_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] frame_width_o;
  logic [15:0] frame_height_o;
  logic [1:0]  parse_status_o;

  h264_sps_frame_size_extractor_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_width_o  (frame_width_o),
    .frame_height_o (frame_height_o),
    .parse_status_o (parse_status_o)
  );

  size_report_t sizes_due[$];
  logic [7:0]   unit_bytes[$];
  bit           sps_bits[$];

  int err_count;
  int bytes_sent;
  int units_sent;
  int reports_seen;
  int status_seen[4];
  bit tx_idle;
  bit rx_idle;
  int rx_hold_cycles;

  // parser model state
  logic [IdxW-1:0] sps_idx;
  phase_t          sps_phase;
  int unsigned     sps_zeros;
  logic [31:0]     sps_acc;
  int unsigned     sps_left;
  logic [31:0]     sps_cycles;
  logic [15:0]     sps_width;
  bit              sps_sent;
  bit              sps_in_suffix;
  bit              sps_pend;
  size_report_t    sps_report;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("h264_sps_frame_size_extractor_top_tb NOT OK");
    $finish;
  end

  function automatic void sps_clear();
    sps_idx       = '0;
    sps_phase     = PH_HEADER;
    sps_zeros     = 0;
    sps_acc       = '0;
    sps_left      = 0;
    sps_cycles    = '0;
    sps_width     = '0;
    sps_sent      = 1'b0;
    sps_in_suffix = 1'b0;
  endfunction

  function automatic void sps_emit(input logic [15:0] w, input logic [15:0] h,
                                   input logic [1:0] st);
    sps_pend          = 1'b1;
    sps_report.width  = w;
    sps_report.height = h;
    sps_report.status = st;
    sps_sent          = 1'b1;
    sps_phase         = PH_DONE;
  endfunction

  function automatic logic [15:0] mb_to_pixels(input logic [31:0] v);
    longint unsigned p;
    p = (longint'(v) + 1) * 16;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic void sps_code_done(input logic [31:0] v);
    case (sps_phase)
      PH_SET_ID:     sps_phase = PH_FRAME_NUM;
      PH_FRAME_NUM:  sps_phase = PH_ORDER_TYPE;
      PH_ORDER_TYPE: begin
        if (v == 0) sps_phase = PH_POC_LSB;
        else if (v == 1) sps_phase = PH_ZERO_FLAG;
        else sps_emit('0, '0, STAT_ORDER);
      end
      PH_POC_LSB:     sps_phase = PH_NUM_REF0;
      PH_NUM_REF0:    sps_phase = PH_GAP_FLAG;
      PH_OFF_NONREF:  sps_phase = PH_OFF_TB;
      PH_OFF_TB:      sps_phase = PH_CYCLE_COUNT;
      PH_CYCLE_COUNT: begin
        sps_cycles = v;
        sps_phase  = (v == 0) ? PH_NUM_REF1 : PH_CYCLE_ENTRY;
      end
      PH_CYCLE_ENTRY: begin
        sps_cycles = sps_cycles - 1;
        if (sps_cycles == 0) sps_phase = PH_NUM_REF1;
      end
      PH_NUM_REF1: sps_phase = PH_GAP_FLAG;
      PH_WIDTH: begin
        sps_width = mb_to_pixels(v);
        sps_phase = PH_HEIGHT;
      end
      PH_HEIGHT: sps_emit(sps_width, mb_to_pixels(v), STAT_OK);
      default:   sps_phase = PH_DONE;
    endcase
  endfunction

  function automatic void sps_take_bit(input logic b);
    longint unsigned v;
    if (sps_phase == PH_ZERO_FLAG) begin
      sps_phase = PH_OFF_NONREF;
      return;
    end
    if (sps_phase == PH_GAP_FLAG) begin
      sps_phase = PH_WIDTH;
      return;
    end
    if (!sps_in_suffix) begin
      if (b == 1'b0 && sps_zeros < MaxPrefixZeros) begin
        sps_zeros++;
        return;
      end
      if (sps_zeros == 0) begin
        sps_code_done('0);
        return;
      end
      sps_in_suffix = 1'b1;
      sps_left      = sps_zeros;
      sps_acc       = '0;
      return;
    end
    sps_acc = {sps_acc[30:0], b};
    sps_left--;
    if (sps_left == 0) begin
      v = (64'd1 << sps_zeros) - 1 + longint'(sps_acc);
      sps_in_suffix = 1'b0;
      sps_zeros     = 0;
      sps_acc       = '0;
      sps_code_done((v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0]);
    end
  endfunction

  function automatic void sps_predict_byte(input logic [7:0] d, input logic l);
    int k;
    sps_pend = 1'b0;
    if (sps_phase == PH_HEADER) begin
      if (sps_idx == ProfileIdx) begin
        if (d == ProfileBase) sps_phase = PH_WAIT_BASE;
        else if (d == ProfileHigh) sps_phase = PH_WAIT_HIGH;
        else sps_emit('0, '0, STAT_PROFILE);
      end
    end else if (sps_phase == PH_WAIT_BASE && sps_idx == BaseStartIdx) begin
      sps_phase = PH_SET_ID;
    end else if (sps_phase == PH_WAIT_HIGH && sps_idx == HighStartIdx) begin
      sps_phase = PH_FRAME_NUM;
    end
    for (k = 7; k >= 0; k--) begin
      if (sps_phase >= PH_SET_ID && sps_phase < PH_DONE) sps_take_bit(d[k]);
    end
    if (sps_idx < IdxMax) sps_idx++;
    if (l && !sps_pend && !sps_sent) sps_emit('0, '0, STAT_TRUNC);
    if (sps_pend) sizes_due.push_back(sps_report);
    if (l) sps_clear();
  endfunction

  // --- unit builder: Exp-Golomb bit writer ---
  function automatic void put_ue(input longint unsigned v);
    longint unsigned n;
    int nb;
    int i;
    n  = v + 1;
    nb = 0;
    while ((n >> (nb + 1)) != 0) nb++;
    repeat (nb) sps_bits.push_back(1'b0);
    for (i = nb; i >= 0; i--) sps_bits.push_back(n[i]);
  endfunction

  // prefix overflows the zero counter; terminator bit is taken whatever its value
  function automatic void put_long_code(input bit term, input logic [31:0] sfx);
    int i;
    repeat (MaxPrefixZeros) sps_bits.push_back(1'b0);
    sps_bits.push_back(term);
    for (i = 31; i >= 0; i--) sps_bits.push_back(sfx[i]);
  endfunction

  function automatic longint unsigned pick_small();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 7);
  endfunction

  function automatic longint unsigned pick_mb();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, 32'hFFFF_FFFE);
    if (r <= 4) return $urandom_range(3900, 5000);
    return $urandom_range(0, 255);
  endfunction

  function automatic void build_sps(input logic [7:0] profile, input longint unsigned order,
                                    input int ncycle, input longint unsigned wmb,
                                    input longint unsigned hmb, input bit long_w);
    logic [7:0] b;
    int i;
    unit_bytes.delete();
    sps_bits.delete();
    unit_bytes.push_back($urandom_range(0, 255));
    unit_bytes.push_back(profile);
    unit_bytes.push_back($urandom_range(0, 255));
    unit_bytes.push_back($urandom_range(0, 255));
    if (profile == ProfileHigh) unit_bytes.push_back($urandom_range(0, 255));
    if (profile != ProfileHigh) put_ue(pick_small());
    put_ue(pick_small());
    put_ue(order);
    if (order == 0) begin
      put_ue(pick_small());
      put_ue(pick_small());
      sps_bits.push_back($urandom_range(0, 1));
    end else if (order == 1) begin
      sps_bits.push_back($urandom_range(0, 1));
      put_ue(pick_small());
      put_ue(pick_small());
      put_ue(ncycle);
      repeat (ncycle) put_ue(pick_small());
      put_ue(pick_small());
      sps_bits.push_back($urandom_range(0, 1));
    end
    if (order <= 1) begin
      if (long_w) put_long_code($urandom_range(0, 1), $urandom);
      else put_ue(wmb);
      put_ue(hmb);
    end
    while (sps_bits.size() % 8 != 0) sps_bits.push_back($urandom_range(0, 1));
    while (sps_bits.size() != 0) begin
      for (i = 7; i >= 0; i--) b[i] = sps_bits.pop_front();
      unit_bytes.push_back(b);
    end
  endfunction

  // --- channel drivers ---
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    sps_predict_byte(d, l);
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_unit(input int cut, input int tail);
    int n;
    int i;
    if (cut > 0) while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
    repeat (tail) unit_bytes.push_back($urandom_range(0, 255));
    n = unit_bytes.size();
    for (i = 0; i < n; i++) send_byte(unit_bytes[i], i == n - 1);
    units_sent++;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  initial begin : rx_drive
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : size_checker
    size_report_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sizes_due.size() == 0) begin
          report_mismatch("unexpected beat status", parse_status_o, -1);
        end else begin
          want = sizes_due.pop_front();
          reports_seen++;
          status_seen[want.status]++;
          if (frame_width_o !== want.width)
            report_mismatch("frame_width", frame_width_o, want.width);
          if (frame_height_o !== want.height)
            report_mismatch("frame_height", frame_height_o, want.height);
          if (parse_status_o !== want.status)
            report_mismatch("parse_status", parse_status_o, want.status);
        end
      end
    end
  end

  // --- tests ---
  task automatic test_baseline_profile();
    build_sps(ProfileBase, 0, 0, 0, 1, 1'b0);
    send_unit(0, 0);
  endtask

  task automatic test_high_profile_cycle_list();
    build_sps(ProfileHigh, 1, 3, 119, 67, 1'b0);
    send_unit(0, 2);
  endtask

  task automatic test_bad_profile();
    unit_bytes = '{8'h67, 8'h4D, 8'hFF};
    send_unit(0, 0);
  endtask

  task automatic test_bad_order_type();
    build_sps(ProfileBase, 2, 0, 0, 0, 1'b0);
    send_unit(0, 0);
  endtask

  task automatic test_truncated();
    unit_bytes = '{8'h00};
    send_unit(0, 0);
    build_sps(ProfileBase, 0, 0, 10, 10, 1'b0);
    send_unit(5, 0);
  endtask

  task automatic test_long_prefix();
    build_sps(ProfileHigh, 0, 0, 0, 32'hFFFF_FFFE, 1'b1);
    send_unit(0, 1);
  endtask

  task automatic test_output_backpressure();
    int i;
    tx_idle        = 1'b0;
    rx_hold_cycles = 400;
    for (i = 0; i < 16; i++) begin
      if (i % 3 == 2) begin
        build_sps(ProfileBase, 0, 0, pick_mb(), pick_mb(), 1'b0);
      end else begin
        unit_bytes = '{8'h67, 8'h00};
      end
      send_unit(0, 0);
    end
    tx_idle = 1'b1;
  endtask

  task automatic test_random_units();
    int kind;
    int n;
    logic [7:0] prof;
    while (bytes_sent < 1900) begin
      if (units_sent % 16 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      prof = $urandom_range(0, 1) ? ProfileBase : ProfileHigh;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        build_sps(prof, $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4),
                  pick_mb(), pick_mb(), 1'b0);
        send_unit(0, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
      end else if (kind < 70) begin
        build_sps(prof, $urandom_range(2, 300), 0, 0, 0, 1'b0);
        send_unit(0, $urandom_range(0, 3));
      end else if (kind < 78) begin
        build_sps($urandom_range(0, 255), 0, 0, pick_mb(), pick_mb(), 1'b0);
        send_unit(0, 0);
      end else if (kind < 88) begin
        build_sps(prof, $urandom_range(0, 1), $urandom_range(0, 4), pick_mb(), pick_mb(),
                  1'b0);
        send_unit($urandom_range(1, unit_bytes.size() - 1), 0);
      end else if (kind < 95) begin
        unit_bytes.delete();
        n = $urandom_range(1, 12);
        repeat (n) unit_bytes.push_back($urandom_range(0, 255));
        send_unit(0, 0);
      end else begin
        build_sps(prof, $urandom_range(0, 1), $urandom_range(0, 2), 0, pick_mb(), 1'b1);
        send_unit(0, $urandom_range(0, 2));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    sps_clear();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_baseline_profile();
    test_high_profile_cycle_list();
    test_bad_profile();
    test_bad_order_type();
    test_truncated();
    test_long_prefix();
    test_output_backpressure();
    test_random_units();

    in_valid_i <= 1'b0;
    while (sizes_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d SPS units (%0d bytes), %0d size reports checked",
             units_sent, bytes_sent, reports_seen);
    $display("report status mix ok/profile/order/truncated: %0d/%0d/%0d/%0d",
             status_seen[STAT_OK], status_seen[STAT_PROFILE], status_seen[STAT_ORDER],
             status_seen[STAT_TRUNC]);
    if (err_count == 0) begin
      $display("h264_sps_frame_size_extractor_top_tb OK");
    end else begin
      $display("h264_sps_frame_size_extractor_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
sv/sfe_pkg.sv
sv/sfe_ucode_rom.sv
sv/sfe_bit_engine.sv
sv/h264_sps_frame_size_extractor_top.sv
dv/h264_sps_frame_size_extractor_top_tb.sv
